// ----- design/banked_memory_io_decoder_assert.svh -----
// Assertion macros shared by the decoder's checker.
`ifndef BANKED_MEMORY_IO_DECODER_ASSERT_SVH
`define BANKED_MEMORY_IO_DECODER_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define BMIO_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bmio: property violated");

// Expression must never be true out of reset.
`define BMIO_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("bmio: forbidden condition seen");

`endif

// ----- design/bmio_pkg.sv -----
// Types, constants and tables of the banked memory and I/O decoder.
`default_nettype none

package bmio_pkg;

	// Memory geometry
	localparam int BANK_COUNT   = 32;
	localparam int BANK_BYTES   = 4096;
	localparam int TEXT_COLUMNS = 80;

	localparam int BANK_W     = $clog2(BANK_COUNT);
	localparam int BANK_SHIFT = $clog2(BANK_BYTES);
	localparam int MEM_SIZE   = 32'hF000 + BANK_COUNT * BANK_BYTES;
	localparam int MEM_AW     = $clog2(MEM_SIZE);
	localparam int CUR_W      = 15;

	typedef logic [BANK_W-1:0] bank_t;
	typedef logic [MEM_AW-1:0] mem_addr_t;
	typedef logic [CUR_W-1:0]  cursor_t;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_KEY   = 2'd2,
		ACT_TICK  = 2'd3
	} action_t;

	// Window and display ranges, as 32-bit physical addresses (WINDOW_ADDR: 16-bit CPU address)
	localparam logic [15:0] WINDOW_ADDR = 16'hF000;
	localparam logic [31:0] WINDOW_BASE = 32'hF000;
	localparam logic [31:0] WINDOW_END  = 32'h11000;
	localparam logic [31:0] GFX_LO      = WINDOW_BASE + 32'(8 * BANK_BYTES);
	localparam logic [31:0] GFX_HI      = WINDOW_BASE + 32'(24 * BANK_BYTES);
	localparam logic [7:0]  VIDEO_GFX   = 8'd1;

	// I/O register addresses
	localparam mem_addr_t IO_BANK    = mem_addr_t'(8'h20);
	localparam mem_addr_t IO_KEY     = mem_addr_t'(8'h21);
	localparam mem_addr_t IO_KEY_PND = mem_addr_t'(8'h22);
	localparam mem_addr_t IO_TICK0   = mem_addr_t'(8'h23);
	localparam mem_addr_t IO_TICK1   = mem_addr_t'(8'h24);
	localparam mem_addr_t IO_TICK2   = mem_addr_t'(8'h25);
	localparam mem_addr_t IO_TICK3   = mem_addr_t'(8'h26);
	localparam mem_addr_t IO_COLUMN  = mem_addr_t'(8'h2C);
	localparam mem_addr_t IO_ROW     = mem_addr_t'(8'h2D);
	localparam mem_addr_t IO_VIDEO   = mem_addr_t'(8'h38);
	localparam mem_addr_t IO_FLAGS   = mem_addr_t'(8'h5F);

	// Written byte reduced to a legal bank number
	typedef bank_t bank_tbl_t [256];

	function automatic bank_tbl_t bank_mod_table();
		bank_tbl_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = BANK_W'(i % BANK_COUNT);
		end
		return t;
	endfunction

	localparam bank_tbl_t BANK_MOD = bank_mod_table();

endpackage

`default_nettype wire

// ----- design/banked_memory_io_decoder.sv -----
// Top level of the banked memory and I/O decoder.
`default_nettype none

// Banked memory and I/O decoder. One request (read, write, key press event or
// frame tick) is taken on every clock at which start is high; busy is always
// low, so requests may come back to back at one per cycle. Each request gives
// exactly one result. In the cycle after the accepting edge the request sits in
// the input register, where the address is banked and decoded and the memory
// is read. The result register loads at the next edge, and done is high for
// the cycle after that, in which the result is to be taken; one request is
// taken and one result given per clock.
// The receiver cannot stall; a result not taken in its done cycle is gone.
// The 188 KB memory is not cleared after reset and needs no clearing pass: a
// read of a byte never written returns garbage. Register side effects of a
// request are visible to the request that follows it directly.
module banked_memory_io_decoder (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            action,
	input  wire logic [15:0]           address,
	input  wire logic [7:0]            data,
	output logic                       done,
	output logic [7:0]                 read_data,
	output logic [bmio_pkg::CUR_W-1:0] cursor_pos,
	output logic                       repaint_request,
	output logic                       mode_changed,
	output logic                       flags_write,
	output logic [7:0]                 flags_value
);
	import bmio_pkg::*;

	// Input register
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;

	// Architectural state
	bank_t       bank_q;
	logic        key_pending_q;
	logic [7:0]  key_code_q;
	logic [31:0] frame_ticks_q;
	logic [7:0]  column_q;
	logic [7:0]  row_q;
	logic [7:0]  video_mode_q;
	cursor_t     lin_cursor_q;

	// Banked memory
	logic [7:0]  mem [MEM_SIZE];

	// Decode of the request in stage 1
	mem_addr_t   pa;
	logic [31:0] pa_wide;
	logic        is_read;
	logic        is_write;
	logic        io_hit;
	logic [7:0]  io_value;
	logic [7:0]  column_nx;
	logic [7:0]  row_nx;
	logic [7:0]  video_mode_nx;
	cursor_t     cursor_calc;
	cursor_t     cursor_nx;
	logic        repaint;

	// Result register
	logic        done_s2;
	logic        rd_sel_s2;
	logic        io_hit_s2;
	logic [7:0]  io_value_s2;
	logic [7:0]  mem_rd_s2;
	cursor_t     cursor_s2;
	logic        repaint_s2;
	logic        mode_chg_s2;
	logic        flags_wr_s2;
	logic [7:0]  flags_val_s2;

	// Every request is taken in one pass; nothing ever holds the port off.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			action_s1  <= action;
			address_s1 <= address;
			data_s1    <= data;
		end
	end

	assign is_read  = valid_s1 && (action_s1 == ACT_READ);
	assign is_write = valid_s1 && (action_s1 == ACT_WRITE);

	// The top 4 KB of the address space is a window moved by the bank register.
	always_comb begin
		if (address_s1 >= WINDOW_ADDR) begin
			pa = mem_addr_t'(address_s1) + (mem_addr_t'(bank_q) << BANK_SHIFT);
		end else begin
			pa = mem_addr_t'(address_s1);
		end
	end

	assign pa_wide = 32'(pa);

	// I/O registers that a read sees in place of memory
	always_comb begin
		io_hit   = 1'b1;
		io_value = 8'h00;
		unique case (pa)
			IO_BANK:    io_value = 8'(bank_q);
			IO_KEY:     io_value = key_code_q;
			IO_KEY_PND: io_value = {7'b0, key_pending_q};
			IO_TICK0:   io_value = frame_ticks_q[7:0];
			IO_TICK1:   io_value = frame_ticks_q[15:8];
			IO_TICK2:   io_value = frame_ticks_q[23:16];
			IO_TICK3:   io_value = frame_ticks_q[31:24];
			IO_COLUMN:  io_value = column_q;
			IO_ROW:     io_value = row_q;
			IO_VIDEO:   io_value = video_mode_q;
			default:    io_hit   = 1'b0;
		endcase
	end

	// Register updates caused by a write
	assign column_nx     = (is_write && pa == IO_COLUMN) ? data_s1 : column_q;
	assign row_nx        = (is_write && pa == IO_ROW)    ? data_s1 : row_q;
	assign video_mode_nx = (is_write && pa == IO_VIDEO)  ? data_s1 : video_mode_q;

	// Linear cursor: columns times row plus column, kept to 15 bits
	assign cursor_calc = CUR_W'(16'(TEXT_COLUMNS) * 16'(row_nx) + 16'(column_nx));
	assign cursor_nx   = (is_write && (pa == IO_COLUMN || pa == IO_ROW)) ?
		cursor_calc : lin_cursor_q;

	// Repaint: the text window, or banks 8 to 23 in graphics mode
	always_comb begin
		repaint = 1'b0;
		if (is_write) begin
			if (pa_wide >= WINDOW_BASE && pa_wide < WINDOW_END) begin
				repaint = 1'b1;
			end else if (video_mode_nx == VIDEO_GFX && pa_wide >= GFX_LO &&
					pa_wide < GFX_HI) begin
				repaint = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q        <= '0;
			key_pending_q <= 1'b0;
			key_code_q    <= 8'h00;
			frame_ticks_q <= 32'h0;
			column_q      <= 8'h00;
			row_q         <= 8'h00;
			video_mode_q  <= 8'h00;
			lin_cursor_q  <= '0;
		end else if (valid_s1) begin
			column_q     <= column_nx;
			row_q        <= row_nx;
			video_mode_q <= video_mode_nx;
			lin_cursor_q <= cursor_nx;
			if (is_write && pa == IO_BANK) begin
				bank_q <= BANK_MOD[data_s1];
			end
			// Reading the key code acknowledges the key.
			if (is_read && pa == IO_KEY) begin
				key_pending_q <= 1'b0;
			end
			if (action_s1 == ACT_KEY) begin
				key_code_q    <= data_s1;
				key_pending_q <= 1'b1;
			end
			if (action_s1 == ACT_TICK) begin
				frame_ticks_q <= frame_ticks_q + 32'd1;
			end
		end
	end

	// Single-port memory: every write is stored, read data is registered.
	always_ff @(posedge clk) begin
		if (is_write) begin
			mem[pa] <= data_s1;
		end
		if (is_read) begin
			mem_rd_s2 <= mem[pa];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rd_sel_s2    <= is_read;
			io_hit_s2    <= io_hit;
			io_value_s2  <= io_value;
			cursor_s2    <= cursor_nx;
			repaint_s2   <= repaint;
			mode_chg_s2  <= is_write && pa == IO_VIDEO;
			flags_wr_s2  <= is_write && pa == IO_FLAGS;
			flags_val_s2 <= (is_write && pa == IO_FLAGS) ? data_s1 : 8'h00;
		end
	end

	// Result ports
	assign done            = done_s2;
	assign read_data       = !rd_sel_s2 ? 8'h00 : (io_hit_s2 ? io_value_s2 : mem_rd_s2);
	assign cursor_pos      = cursor_s2;
	assign repaint_request = repaint_s2;
	assign mode_changed    = mode_chg_s2;
	assign flags_write     = flags_wr_s2;
	assign flags_value     = flags_val_s2;

endmodule

`default_nettype wire

// ----- design/bmio_checker.sv -----
// Port-level checker of the banked memory and I/O decoder, with its bind.
`default_nettype none

`include "banked_memory_io_decoder_assert.svh"

module bmio_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] action,
	input wire logic       done,
	input wire logic [7:0] read_data,
	input wire logic       repaint_request,
	input wire logic       mode_changed,
	input wire logic       flags_write
);
	import bmio_pkg::*;

	// Requests are never refused.
	`BMIO_NEVER(a_never_busy, busy)
	// One result for each request, and none without one.
	`BMIO_ASSERT(a_result_follows, start |-> ##2 done)
	`BMIO_ASSERT(a_no_spurious, !start |-> ##2 !done)
	// Only a write raises the side-effect strobes.
	`BMIO_ASSERT(a_strobes_on_write,
		start && action != ACT_WRITE |-> ##2 !flags_write && !mode_changed && !repaint_request)
	// Anything but a read returns zero data.
	`BMIO_ASSERT(a_zero_unless_read, start && action != ACT_READ |-> ##2 read_data == 8'h00)

endmodule

bind banked_memory_io_decoder bmio_checker u_bmio_checker (.*);

`default_nettype wire
